>>> sv/fbla_pkg.sv
// ----------------------------------------------------------------------------
// fbla_pkg
// Shared codes, field widths and the result record of the free-list block
// allocator.
// ----------------------------------------------------------------------------
package fbla_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_ALLOC = 2'd1;
   localparam logic [1:0] REQ_FREE  = 2'd2;

   // result status carried in rsp_tuser
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_BASE_ADDRESS    = 2'd0;
   localparam logic [1:0] CSR_POOL_CAPACITY   = 2'd1;
   localparam logic [1:0] CSR_BLOCK_SIZE      = 2'd2;
   localparam logic [1:0] CSR_BLOCK_ALIGNMENT = 2'd3;

   // field widths
   localparam int SLOT_FIELD_W = 10;
   localparam int ADDR_FIELD_W = 33;
   localparam int BYTES_W      = 32;
   localparam int LIVE_W       = 11;
   localparam int BSIZE_W      = 16;
   localparam int ALIGN_W      = 8;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 88;

   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
   localparam logic [LIVE_W-1:0]  LIVE_MAX  = '1;

   // one result item
   typedef struct packed {
      logic                    status;
      logic [SLOT_FIELD_W-1:0] granted_slot;
      logic [ADDR_FIELD_W-1:0] granted_address;
      logic [BYTES_W-1:0]      bytes_in_use;
      logic [LIVE_W-1:0]       live_allocations;
   } result_type;

endpackage

>>> sv/fbla_link_mem.sv
// ----------------------------------------------------------------------------
// fbla_link_mem
// Next-slot link memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module fbla_link_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] link_mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write the link entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem_ff[wr_addr] <= wr_data;
      end
   end

   // register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= link_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/fixed_block_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// Pool allocator for equal-size blocks, with a linked free list held in a
// next-slot memory.
// ----------------------------------------------------------------------------
// An allocate or a free first registers the link memory read and the
// slot-times-size product at acceptance, then updates the list head and the
// counters and loads the result register. A clear walks the slots, building at
// most MAX_SLOTS, then terminates the chain and loads the result; when the
// capacity is below the alignment padding or the block size is zero it skips
// the walk. A single 32-bit subtract-and-compare unit takes one block size off
// the remaining capacity per cycle while the link memory is written one entry
// per cycle, so no divider is needed. One item is worked on at a time; the next
// item is accepted once the sequencer is idle and the result register is empty
// or being taken.
module fixed_block_free_list_allocator_top
   import fbla_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [9:0] free_slot, [15:10] zero
   input  logic [1:0]            req_tuser,  // [1:0] req_type
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [9:0] granted_slot, [42:10] granted_address, [74:43] bytes_in_use,
   // [85:75] live_allocations, [87:86] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,  // [0] status
   // configuration port
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   localparam int SLOT_W = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
   localparam int LINK_W = $clog2(MAX_SLOTS + 1);
   localparam int PROD_W = SLOT_W + BSIZE_W;
   localparam logic [LINK_W-1:0] NULL_MARK = LINK_W'(MAX_SLOTS);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ALLOC    = 3'd1;
   localparam logic [2:0] ST_FREE     = 3'd2;
   localparam logic [2:0] ST_CLR_WALK = 3'd3;
   localparam logic [2:0] ST_CLR_END  = 3'd4;

   // configuration registers
   logic [31:0]        base_address_ff;
   logic [31:0]        pool_capacity_ff;
   logic [BSIZE_W-1:0] block_size_ff;
   logic [ALIGN_W-1:0] block_alignment_ff;

   // sequencer and list state
   logic [2:0]         state_ff, state_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [BYTES_W-1:0] used_bytes_ff, used_bytes_in;
   logic [LIVE_W-1:0]  alloc_total_ff, alloc_total_in;
   logic [LINK_W-1:0]  idx_ff, idx_in;
   logic [31:0]        rem_ff, rem_in;
   logic               free_ok_ff, free_ok_in;
   logic [SLOT_W-1:0]  free_slot_ff, free_slot_in;

   // operand registers for the allocate address
   logic [PROD_W-1:0]       prod_ff;
   logic [ADDR_FIELD_W-1:0] aligned_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   // link memory ports
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [LINK_W-1:0] mem_wdata;
   logic [LINK_W-1:0] mem_rdata;

   // combinational helpers
   logic [ALIGN_W-1:0]      align_mask;
   logic [ALIGN_W-1:0]      adj;
   logic                    accept;
   logic [32:0]             walk_diff;
   logic [BYTES_W:0]        used_sum;
   logic [15:0]             req_slot_ext;
   logic [ADDR_FIELD_W-1:0] alloc_addr;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   // alignment adjustment of the base address; zero alignment counts as one
   assign align_mask = (block_alignment_ff == '0) ? '0 : block_alignment_ff - 1'b1;
   assign adj = (ALIGN_W'(0) - base_address_ff[ALIGN_W-1:0]) & align_mask;

   // subtract-and-compare unit of the clear walk
   assign walk_diff = {1'b0, rem_ff} - {17'd0, block_size_ff};

   assign used_sum     = {1'b0, used_bytes_ff} + (BYTES_W + 1)'(block_size_ff);
   assign req_slot_ext = 16'(req_tdata[SLOT_FIELD_W-1:0]);
   assign alloc_addr   = aligned_ff + ADDR_FIELD_W'(prod_ff);

   // link memory
   fbla_link_mem #(
      .DEPTH  (MAX_SLOTS),
      .ADDR_W (SLOT_W),
      .DATA_W (LINK_W)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (head_ff[SLOT_W-1:0]),
      .rd_data (mem_rdata)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      used_bytes_in  = used_bytes_ff;
      alloc_total_in = alloc_total_ff;
      idx_in         = idx_ff;
      rem_in         = rem_ff;
      free_ok_in     = free_ok_ff;
      free_slot_in   = free_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff[SLOT_W-1:0];
      mem_wdata      = idx_ff + 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               free_slot_in = req_tdata[SLOT_W-1:0];
               free_ok_in   = (req_tuser == REQ_FREE) &&
                              (32'(req_slot_ext) < 32'(MAX_SLOTS));
               idx_in       = '0;
               rem_in       = pool_capacity_ff - 32'(adj);
               if (req_tuser == REQ_CLEAR) begin
                  if (block_size_ff != '0 && pool_capacity_ff >= 32'(adj)) begin
                     state_in = ST_CLR_WALK;
                  end else begin
                     state_in = ST_CLR_END;
                  end
               end else if (req_tuser == REQ_ALLOC) begin
                  state_in = ST_ALLOC;
               end else begin
                  state_in = ST_FREE;
               end
            end
         end
         ST_ALLOC: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.bytes_in_use     = used_bytes_ff;
            rsp_in.live_allocations = alloc_total_ff;
            if (head_ff >= NULL_MARK) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.status          = STATUS_OK;
               rsp_in.granted_slot    = SLOT_FIELD_W'(head_ff);
               rsp_in.granted_address = alloc_addr;
               head_in = mem_rdata;
               used_bytes_in = used_sum[BYTES_W] ? BYTES_MAX : used_sum[BYTES_W-1:0];
               if (alloc_total_ff != LIVE_MAX) begin
                  alloc_total_in = alloc_total_ff + 1'b1;
               end
               rsp_in.bytes_in_use     = used_bytes_in;
               rsp_in.live_allocations = alloc_total_in;
            end
            state_in = ST_IDLE;
         end
         ST_FREE: begin
            if (free_ok_ff) begin
               mem_we    = 1'b1;
               mem_waddr = free_slot_ff;
               mem_wdata = head_ff;
               head_in   = LINK_W'(free_slot_ff);
               used_bytes_in = (used_bytes_ff > BYTES_W'(block_size_ff)) ?
                               used_bytes_ff - BYTES_W'(block_size_ff) : '0;
               if (alloc_total_ff != '0) begin
                  alloc_total_in = alloc_total_ff - 1'b1;
               end
            end
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.status           = STATUS_OK;
            rsp_in.bytes_in_use     = used_bytes_in;
            rsp_in.live_allocations = alloc_total_in;
            state_in = ST_IDLE;
         end
         ST_CLR_WALK: begin
            // chain one more slot while a whole block still fits
            if (!walk_diff[32] && idx_ff < NULL_MARK) begin
               mem_we = 1'b1;
               rem_in = walk_diff[31:0];
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_CLR_END;
            end
         end
         ST_CLR_END: begin
            // terminate the chain at the last slot built
            if (idx_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = SLOT_W'(idx_ff - 1'b1);
               mem_wdata = NULL_MARK;
               head_in   = '0;
            end else begin
               head_in = NULL_MARK;
            end
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.status           = STATUS_OK;
            rsp_in.bytes_in_use     = used_bytes_ff;
            rsp_in.live_allocations = alloc_total_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= NULL_MARK;
         used_bytes_ff  <= '0;
         alloc_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         used_bytes_ff  <= used_bytes_in;
         alloc_total_ff <= alloc_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload and operand registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      rem_ff       <= rem_in;
      free_ok_ff   <= free_ok_in;
      free_slot_ff <= free_slot_in;
      rsp_ff       <= rsp_in;
      prod_ff      <= PROD_W'(head_ff[SLOT_W-1:0]) * PROD_W'(block_size_ff);
      aligned_ff   <= ADDR_FIELD_W'(base_address_ff) + ADDR_FIELD_W'(adj);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff    <= '0;
         pool_capacity_ff   <= '0;
         block_size_ff      <= BSIZE_W'(8);
         block_alignment_ff <= ALIGN_W'(8);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS:    base_address_ff    <= csr_wdata;
            CSR_POOL_CAPACITY:   pool_capacity_ff   <= csr_wdata;
            CSR_BLOCK_SIZE:      block_size_ff      <= csr_wdata[BSIZE_W-1:0];
            CSR_BLOCK_ALIGNMENT: block_alignment_ff <= csr_wdata[ALIGN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // drive the result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {2'b00, rsp_ff.live_allocations, rsp_ff.bytes_in_use,
                        rsp_ff.granted_address, rsp_ff.granted_slot};

endmodule

>>> bench/tb_fixed_block_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator_top
// Self-checking bench for the free-list block allocator. A directed table
// covers reset state, the empty pool, short pools, the largest addresses and
// live reconfiguration. Random phases follow with allocate, free and clear
// under every idling mix. A short run on a slot linked to itself closes the
// sequence. Each result is compared against a table entry or an in-bench model.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator_top;
   import fbla_pkg::*;

   localparam int          SLOT_COUNT     = 1024;
   localparam logic [10:0] NULL_SLOT      = 11'd1024;
   localparam int          WATCHDOG_LIMIT = 8000;
   localparam int          PHASES         = 8;
   localparam int          PHASE_ITEMS    = 66;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [31:0]        base;
      logic [31:0]        capacity;
      logic [BSIZE_W-1:0] bsize;
      logic [ALIGN_W-1:0] align;
   } pool_cfg_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   op;
      logic [9:0]   slot;
      pool_cfg_type cfg;
      logic         typed;
      result_type   want;
   } stim_row_type;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [1:0]              pad;
      logic [LIVE_W-1:0]       live;
      logic [BYTES_W-1:0]      bytes;
      logic [ADDR_FIELD_W-1:0] addr;
      logic [SLOT_FIELD_W-1:0] slot;
   } rsp_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [9:0] free_slot, [15:10] zero
   logic [1:0]            req_tuser  = '0;   // [1:0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [9:0] granted_slot, [42:10] granted_address, [74:43] bytes_in_use,
   // [85:75] live_allocations, [87:86] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;         // [0] status
   logic                  csr_we     = 1'b0;
   logic [1:0]            csr_index  = '0;
   logic [31:0]           csr_wdata  = '0;

   fixed_block_free_list_allocator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // pool image: configuration, link chain and counters
   logic [31:0]        pool_base  = '0;
   logic [31:0]        pool_size  = '0;
   logic [BSIZE_W-1:0] blk_size   = 16'd8;
   logic [ALIGN_W-1:0] blk_align  = 8'd8;
   logic [10:0]        chain_next [SLOT_COUNT];
   logic [10:0]        free_head  = NULL_SLOT;
   logic [31:0]        bytes_held = '0;
   logic [10:0]        blocks_out = '0;

   result_type   expected_q [$];
   logic [9:0]   held_slots [$];
   stim_row_type plan [$];
   result_type   want_r;
   rsp_word_type got_w;
   int           send_gap_pct = 0;
   int           stall_pct    = 0;
   int           mismatches   = 0;
   int           quiet_cycles = 0;
   int           clears = 0, allocs = 0, frees = 0, checked = 0, empties = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // padding from the base up to the next aligned address
   function automatic logic [31:0] pad_for(logic [31:0] base, logic [7:0] align);
      logic [31:0] a;
      a = (align == 8'd0) ? 32'd1 : {24'd0, align};
      return (32'd0 - base) & (a - 32'd1);
   endfunction

   // advance the pool image by one request and return its answer
   function automatic result_type predict_item(logic [1:0] op, logic [9:0] slot);
      result_type  r;
      logic [31:0] pad;
      logic [31:0] n;
      logic [10:0] s;
      int          i;
      r = '0;
      r.status = STATUS_OK;
      pad = pad_for(pool_base, blk_align);
      case (op)
         REQ_CLEAR: begin
            n = 0;
            if (blk_size != 0 && pool_size >= pad) n = (pool_size - pad) / blk_size;
            if (n > SLOT_COUNT) n = SLOT_COUNT;
            if (n == 0) begin
               free_head = NULL_SLOT;
            end else begin
               for (i = 0; i < n - 1; i++) chain_next[i] = 11'(i + 1);
               chain_next[n - 1] = NULL_SLOT;
               free_head = '0;
            end
         end
         REQ_ALLOC: begin
            if (free_head >= NULL_SLOT) begin
               r.status = STATUS_EMPTY;
            end else begin
               s = free_head;
               free_head = chain_next[s[9:0]];
               r.granted_slot = s[9:0];
               r.granted_address = {1'b0, pool_base} + {1'b0, pad}
                                 + {22'd0, s} * {17'd0, blk_size};
               if ({1'b0, bytes_held} + {17'd0, blk_size} > {1'b0, BYTES_MAX})
                  bytes_held = BYTES_MAX;
               else
                  bytes_held = bytes_held + blk_size;
               if (blocks_out < LIVE_MAX) blocks_out = blocks_out + 1'b1;
            end
         end
         REQ_FREE: begin
            chain_next[slot] = free_head;
            free_head = {1'b0, slot};
            bytes_held = (bytes_held > blk_size) ? bytes_held - blk_size : '0;
            if (blocks_out != 0) blocks_out = blocks_out - 1'b1;
         end
         default: ;
      endcase
      r.bytes_in_use = bytes_held;
      r.live_allocations = blocks_out;
      return r;
   endfunction

   function automatic stim_row_type model_row(logic [1:0] op, logic [9:0] slot);
      stim_row_type row;
      row = '{kind: ROW_REQ, op: op, slot: slot, cfg: '0, typed: 1'b0, want: '0};
      return row;
   endfunction

   function automatic stim_row_type fixed_row(logic [1:0] op, logic [9:0] slot, logic st,
                                              logic [9:0] gs, logic [32:0] ga,
                                              logic [31:0] by, logic [10:0] lv);
      stim_row_type row;
      row = model_row(op, slot);
      row.typed = 1'b1;
      row.want.status = st;
      row.want.granted_slot = gs;
      row.want.granted_address = ga;
      row.want.bytes_in_use = by;
      row.want.live_allocations = lv;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(logic [31:0] base, logic [31:0] cap,
                                            logic [15:0] bsize, logic [7:0] align);
      stim_row_type row;
      row = model_row(REQ_CLEAR, '0);
      row.kind = ROW_CFG;
      row.cfg = {base, cap, bsize, align};
      return row;
   endfunction

   task automatic put_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // hold requests, drain the block, then write all four registers
   task automatic program_pool(input pool_cfg_type c);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      put_reg(CSR_BASE_ADDRESS, c.base);
      put_reg(CSR_POOL_CAPACITY, c.capacity);
      put_reg(CSR_BLOCK_SIZE, {16'd0, c.bsize});
      put_reg(CSR_BLOCK_ALIGNMENT, {24'd0, c.align});
      @(negedge clock);
      csr_we <= 1'b0;
      pool_base = c.base;
      pool_size = c.capacity;
      blk_size  = c.bsize;
      blk_align = c.align;
   endtask

   // offer one item; valid stays high after acceptance until the next item
   task automatic send_item(input logic [1:0] op, input logic [9:0] slot,
                            input logic typed, input result_type known);
      result_type r;
      @(negedge clock);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - SLOT_FIELD_W){1'b0}}, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_item(op, slot);
      expected_q.push_back(typed ? known : r);
      case (op)
         REQ_CLEAR: begin
            clears++;
            held_slots.delete();
         end
         REQ_ALLOC: begin
            allocs++;
            if (r.status == STATUS_OK) held_slots.push_back(r.granted_slot);
         end
         default: frees++;
      endcase
   endtask

   function automatic void set_idling(idle_mode_type mode);
      send_gap_pct = (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 31 : 0;
      stall_pct    = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 31 : 0;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // receiver back-pressure
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         checked++;
         if (expected_q.size() == 0) begin
            $error("result item arrived with no request outstanding");
            mismatches++;
         end else begin
            want_r = expected_q.pop_front();
            got_w  = rsp_tdata;
            if (want_r.status == STATUS_EMPTY) empties++;
            check_field("status", 64'(want_r.status), 64'(rsp_tuser));
            check_field("granted_slot", 64'(want_r.granted_slot), 64'(got_w.slot));
            check_field("granted_address", 64'(want_r.granted_address), 64'(got_w.addr));
            check_field("bytes_in_use", 64'(want_r.bytes_in_use), 64'(got_w.bytes));
            check_field("live_allocations", 64'(want_r.live_allocations),
                        64'(got_w.live));
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      pool_cfg_type cfg;
      logic [31:0]  pad;
      logic [9:0]   slot;
      int           roll, pick, phase, n;

      for (n = 0; n < SLOT_COUNT; n++) chain_next[n] = '0;

      // directed table: reset state, empty and short pools, extremes, live config
      plan.push_back(fixed_row(REQ_ALLOC, 10'd0, STATUS_EMPTY, 10'd0, 33'd0, 32'd0, 11'd0));
      plan.push_back(fixed_row(REQ_FREE, 10'd1023, STATUS_OK, 10'd0, 33'd0, 32'd0, 11'd0));
      plan.push_back(fixed_row(REQ_ALLOC, 10'd0, STATUS_OK, 10'd1023, 33'd8184, 32'd8,
                               11'd1));
      plan.push_back(fixed_row(REQ_ALLOC, 10'd0, STATUS_EMPTY, 10'd0, 33'd0, 32'd8, 11'd1));
      plan.push_back(fixed_row(REQ_CLEAR, 10'd0, STATUS_OK, 10'd0, 33'd0, 32'd8, 11'd1));
      plan.push_back(fixed_row(REQ_ALLOC, 10'd0, STATUS_EMPTY, 10'd0, 33'd0, 32'd8, 11'd1));
      plan.push_back(fixed_row(REQ_FREE, 10'd0, STATUS_OK, 10'd0, 33'd0, 32'd0, 11'd0));
      // double free of the same slot, counters held at zero
      plan.push_back(fixed_row(REQ_FREE, 10'd0, STATUS_OK, 10'd0, 33'd0, 32'd0, 11'd0));
      // capacity below the alignment padding
      plan.push_back(cfg_row(32'hFFFF_FFFF, 32'd0, 16'd8, 8'd128));
      plan.push_back(fixed_row(REQ_CLEAR, 10'd0, STATUS_OK, 10'd0, 33'd0, 32'd0, 11'd0));
      plan.push_back(fixed_row(REQ_ALLOC, 10'd0, STATUS_EMPTY, 10'd0, 33'd0, 32'd0, 11'd0));
      // three largest blocks just past the 32-bit address boundary
      plan.push_back(cfg_row(32'hFFFF_FFFF, 32'd196706, 16'd65535, 8'd128));
      plan.push_back(model_row(REQ_CLEAR, 10'd0));
      plan.push_back(fixed_row(REQ_ALLOC, 10'd0, STATUS_OK, 10'd0, 33'h1_0000_0000,
                               32'd65535, 11'd1));
      plan.push_back(model_row(REQ_ALLOC, 10'd0));
      plan.push_back(model_row(REQ_ALLOC, 10'd0));
      plan.push_back(fixed_row(REQ_ALLOC, 10'd0, STATUS_EMPTY, 10'd0, 33'd0, 32'd196605,
                               11'd3));
      plan.push_back(model_row(REQ_FREE, 10'd1));
      plan.push_back(model_row(REQ_ALLOC, 10'd0));
      // full capacity, slot count capped
      plan.push_back(cfg_row(32'h0000_1234, 32'hFFFF_FFFF, 16'd8, 8'd1));
      plan.push_back(model_row(REQ_CLEAR, 10'd0));
      plan.push_back(model_row(REQ_ALLOC, 10'd0));
      // new size and alignment without a rebuild
      plan.push_back(cfg_row(32'h0000_1234, 32'hFFFF_FFFF, 16'd16, 8'd64));
      plan.push_back(model_row(REQ_ALLOC, 10'd0));
      plan.push_back(model_row(REQ_FREE, 10'd0));
      plan.push_back(model_row(REQ_FREE, 10'h155));

      // hold reset, then release it at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);
      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CFG)
            program_pool(plan[k].cfg);
         else
            send_item(plan[k].op, plan[k].slot, plan[k].typed, plan[k].want);
      end

      // random phases: mostly well-formed alloc/free traffic, some stray frees and clears
      for (phase = 0; phase < PHASES; phase++) begin
         cfg.base  = $urandom();
         cfg.align = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 128))
                                              : 8'(1 << $urandom_range(0, 7));
         cfg.bsize = ($urandom_range(2) == 0) ? 16'($urandom_range(8, 65535))
                                              : 16'($urandom_range(8, 64));
         pad = pad_for(cfg.base, cfg.align);
         if (phase % 3 == 2)
            cfg.capacity = 32'hFFFF_FFFF;
         else
            cfg.capacity = pad + $urandom_range(0, 40) * cfg.bsize
                         + $urandom_range(0, cfg.bsize - 1);
         set_idling(idle_mode_type'(phase % 4));
         program_pool(cfg);
         if ($urandom_range(4) != 0) send_item(REQ_CLEAR, 10'd0, 1'b0, '0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
               send_item(REQ_CLEAR, 10'($urandom_range(1023)), 1'b0, '0);
            end else if (roll < 52 || held_slots.size() == 0 && roll < 75) begin
               send_item(REQ_ALLOC, 10'($urandom_range(1023)), 1'b0, '0);
            end else begin
               if (held_slots.size() != 0 && $urandom_range(9) < 8) begin
                  pick = $urandom_range(held_slots.size() - 1);
                  slot = held_slots[pick];
                  held_slots.delete(pick);
               end else begin
                  slot = 10'($urandom_range(1023));
               end
               send_item(REQ_FREE, slot, 1'b0, '0);
            end
         end
      end

      // loop one slot onto itself, allocate from it a few times and hand it back
      set_idling(IDLE_NONE);
      cfg.base     = $urandom();
      cfg.capacity = 32'd1000000;
      cfg.bsize    = 16'd65535;
      cfg.align    = 8'd1;
      program_pool(cfg);
      send_item(REQ_FREE, 10'd5, 1'b0, '0);
      send_item(REQ_FREE, 10'd5, 1'b0, '0);
      for (n = 0; n < 4; n++) send_item(REQ_ALLOC, 10'd0, 1'b0, '0);
      for (n = 0; n < 3; n++) send_item(REQ_FREE, 10'd5, 1'b0, '0);

      // drain and let the block settle
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d requests (%0d clear, %0d allocate, %0d free), checked %0d results.",
               clears + allocs + frees, clears, allocs, frees, checked);
      $display("%0d allocates met an empty pool; clears, stray frees and a self-linked slot ran.",
               empties);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
